// File: design/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and round functions for the ChaCha20 byte cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

  // Default number of double rounds (column plus diagonal).
  localparam int unsigned DoubleRoundsDef = 10;
  // Default depth of the input queue between front and back.
  localparam int unsigned QueueDepthDef   = 2;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned BlockBits  = BlockBytes * 8;
  localparam int unsigned PosW       = 7;
  localparam int unsigned CfgIdxW    = 4;
  localparam int unsigned CfgDataW   = 64;

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY0   = 4'd0,
    CFG_KEY1   = 4'd1,
    CFG_KEY2   = 4'd2,
    CFG_KEY3   = 4'd3,
    CFG_NONCE0 = 4'd4,
    CFG_NONCE1 = 4'd5,
    CFG_CTR    = 4'd6,
    CFG_MODE   = 4'd7
  } cfg_idx_e;

  typedef logic [15:0][31:0] state_t;

  // One queued transaction.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // Control from the buffer logic to the block generator.
  typedef struct packed {
    logic start;
    logic abort;
  } gen_ctrl_t;

  // Status from the block generator.
  typedef struct packed {
    logic busy;
    logic done;
  } gen_stat_t;

  // One quarter round on words a, b, c, d (returned in that order, a lowest).
  function automatic logic [3:0][31:0] qround(input logic [31:0] a_in,
                                              input logic [31:0] b_in,
                                              input logic [31:0] c_in,
                                              input logic [31:0] d_in);
    logic [31:0] a, b, c, d;
    logic [3:0][31:0] res;
    a = a_in; b = b_in; c = c_in; d = d_in;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    res[0] = a; res[1] = b; res[2] = c; res[3] = d;
    return res;
  endfunction

  // One half of a double round: four column or four diagonal quarter rounds.
  function automatic state_t half_round(input state_t w, input logic diag);
    state_t col, dia;
    logic [3:0][31:0] q;
    col = w;
    dia = w;
    for (int i = 0; i < 4; i++) begin
      q = qround(w[i], w[4+i], w[8+i], w[12+i]);
      col[i] = q[0]; col[4+i] = q[1]; col[8+i] = q[2]; col[12+i] = q[3];
      q = qround(w[i], w[4+((i+1)%4)], w[8+((i+2)%4)], w[12+((i+3)%4)]);
      dia[i] = q[0]; dia[4+((i+1)%4)] = q[1];
      dia[8+((i+2)%4)] = q[2]; dia[12+((i+3)%4)] = q[3];
    end
    return diag ? dia : col;
  endfunction

endpackage

// File: design/cc20_queue.sv
// ----------------------------------------------------------------------------
// cc20_queue
// Front queue: accepts input transactions and holds them for the back end.
// ----------------------------------------------------------------------------
module cc20_queue #(
  parameter int unsigned DEPTH = cc20_pkg::QueueDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cc20_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output cc20_pkg::item_t head_o
);
  import cc20_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  item_t           mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_item_i;
  end

endmodule

// File: design/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Block generator: one half round per cycle, then the feed-forward addition.
// ----------------------------------------------------------------------------
module cc20_core #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cc20_pkg::gen_ctrl_t                 ctrl_i,
  input  logic [7:0][31:0]                    key_i,
  input  logic [2:0][31:0]                    nonce_i,
  input  logic [31:0]                         ctr_i,
  output cc20_pkg::gen_stat_t                 stat_o,
  output logic [cc20_pkg::BlockBits-1:0]      block_o
);
  import cc20_pkg::*;

  localparam int unsigned NumRounds = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RndW      = $clog2(NumRounds + 1);
  localparam logic [RndW-1:0] LastRnd = RndW'(NumRounds - 1);

  state_t          init_q, work_q, init_w;
  logic [RndW-1:0] rnd_q;
  logic            busy_q, done_q;

  // Input state from constants, key, counter and nonce.
  always_comb begin
    init_w[0] = Sigma0;
    init_w[1] = Sigma1;
    init_w[2] = Sigma2;
    init_w[3] = Sigma3;
    for (int i = 0; i < 8; i++) init_w[4+i] = key_i[i];
    init_w[12] = ctr_i;
    for (int i = 0; i < 3; i++) init_w[13+i] = nonce_i[i];
  end

  // Round sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.abort) begin
        busy_q <= 1'b0;
      end else if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 1'b1;
        if (rnd_q == LastRnd) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working state.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      init_q <= init_w;
      work_q <= init_w;
    end else if (busy_q) begin
      work_q <= half_round(work_q, rnd_q[0]);
    end
  end

  // Feed-forward addition, serialized little-endian.
  always_comb begin
    for (int k = 0; k < 16; k++) block_o[k*32 +: 32] = work_q[k] + init_q[k];
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q && !ctrl_i.abort;

endmodule

// File: design/chacha20_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 byte stream cipher with a prefetching block generator.
// ----------------------------------------------------------------------------
// Input transactions carry one data byte and a last flag; each gives one
// output transaction with the byte XORed with the next keystream byte, or
// the keystream byte alone in keystream-only mode. A channel moves a
// transaction at a clock edge where valid is high and stall is low.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while the block is idle, which the block does not enforce.
// Writing the start counter reloads the counter and empties the keystream
// buffer. Indexes above seven are ignored. A byte passes the input queue and
// the output register once keystream is ready. The block generator runs one
// half round per cycle and fills a spare block while the current one is used,
// so the sustained rate is one byte per cycle while the receiver does not
// stall. The first byte after reset or a counter write waits for one block.
// Reset clears the control and configuration registers, not the data ones,
// and empties the buffer. When the receiver stalls, the output register
// holds and the two-entry input queue fills, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top #(
  parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DoubleRoundsDef,
  parameter int unsigned QUEUE_DEPTH   = cc20_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    out_byte_o,
  output logic                          last_out_o,
  input  logic                          cfg_we_i,
  input  logic [cc20_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cc20_pkg::CfgDataW-1:0] cfg_data_i
);
  import cc20_pkg::*;

  logic [7:0][31:0]       key_q;
  logic [2:0][31:0]       nonce_q;
  logic [31:0]            ctr_q;
  logic                   mode_q;
  logic [BlockBits-1:0]   cur_q, nxt_q, gen_block;
  logic                   nxt_valid_q;
  logic [PosW-1:0]        pos_q;
  logic                   out_valid_q, out_last_q;
  logic [7:0]             out_byte_q;
  logic                   q_empty, q_full, pop, ks_avail, cfg_hit, buf_empty;
  logic [7:0]             ks_byte;
  item_t                  in_item, head;
  gen_ctrl_t              gen_ctrl;
  gen_stat_t              gen_stat;

  // Front: input queue.
  assign in_item.data = data_byte_i;
  assign in_item.last = last_in_i;
  assign in_stall_o   = q_full;

  cc20_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i, .rst_ni,
    .push_i(in_valid_i), .push_item_i(in_item), .full_o(q_full),
    .pop_i(pop), .empty_o(q_empty), .head_o(head)
  );

  // Back: block generator.
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3,
        CFG_NONCE0, CFG_NONCE1, CFG_CTR: cfg_hit = 1'b1;
        default: cfg_hit = 1'b0;
      endcase
    end
  end

  assign gen_ctrl.abort = cfg_hit;
  assign gen_ctrl.start = !cfg_hit && !nxt_valid_q && !gen_stat.busy && !gen_stat.done;

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i, .rst_ni,
    .ctrl_i(gen_ctrl), .key_i(key_q), .nonce_i(nonce_q), .ctr_i(ctr_q),
    .stat_o(gen_stat), .block_o(gen_block)
  );

  // Keystream selection: the spare block starts when the current one is used up.
  assign buf_empty = pos_q[PosW-1];
  assign ks_avail  = !buf_empty || nxt_valid_q;
  assign ks_byte   = buf_empty ? nxt_q[7:0] : cur_q[pos_q[PosW-2:0]*8 +: 8];
  assign pop       = !q_empty && ks_avail && (!out_valid_q || !out_stall_i);

  // Configuration registers, position, counter and spare block state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_q     <= '0;
      ctr_q       <= '0;
      mode_q      <= 1'b0;
      pos_q       <= PosW'(BlockBytes);
      nxt_valid_q <= 1'b0;
    end else begin
      if (gen_stat.done) nxt_valid_q <= 1'b1;
      if (pop) begin
        if (buf_empty) begin
          pos_q       <= PosW'(1);
          nxt_valid_q <= 1'b0;
          ctr_q       <= ctr_q + 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (cfg_hit) nxt_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_KEY0:   key_q[1:0] <= cfg_data_i;
          CFG_KEY1:   key_q[3:2] <= cfg_data_i;
          CFG_KEY2:   key_q[5:4] <= cfg_data_i;
          CFG_KEY3:   key_q[7:6] <= cfg_data_i;
          CFG_NONCE0: nonce_q[1:0] <= cfg_data_i;
          CFG_NONCE1: nonce_q[2] <= cfg_data_i[31:0];
          CFG_CTR: begin
            ctr_q <= cfg_data_i[31:0];
            pos_q <= PosW'(BlockBytes);
          end
          CFG_MODE:   mode_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // Keystream block storage.
  always_ff @(posedge clk_i) begin
    if (gen_stat.done) nxt_q <= gen_block;
    if (pop && buf_empty) cur_q <= nxt_q;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_byte_q <= mode_q ? ks_byte : (head.data ^ ks_byte);
      out_last_q <= head.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_out_o  = out_last_q;

  // A byte is only taken when keystream is present.
  a_pop_ks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!buf_empty || nxt_valid_q))
    else $error("byte consumed without keystream");

  // The position never passes the end of the block.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(BlockBytes))
    else $error("buffer position out of range");

  // The generator never finishes over a pending spare block.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_stat.done |-> !nxt_valid_q)
    else $error("spare block overwritten");

  // Taking the spare block advances the block counter.
  a_ctr_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && buf_empty && !cfg_we_i) |=> (ctr_q == $past(ctr_q) + 32'd1))
    else $error("block counter did not advance");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ChaCha20 byte stream cipher.
// ----------------------------------------------------------------------------
// Bytes are streamed through the cipher in phases. Most phases first write
// some of the key, nonce, start counter and mode while the block is idle.
// A scoreboard keeps its own ChaCha20 keystream generator and predicts every
// output byte. The input side idles and the output side stalls at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cc20_pkg::*;

  localparam int unsigned WatchLimit = 20000;

  // Keystream predictor and queue of expected output bytes.
  class cipher_scoreboard;
    logic [63:0] key_q[4];
    logic [63:0] nonce_lo;
    logic [31:0] nonce_hi;
    logic [31:0] block_ctr;
    logic        raw_mode;
    logic [7:0]  ks_buf[64];
    int unsigned ks_pos;
    logic [8:0]  pending_q[$];
    bit          failed;

    function new();
      foreach (key_q[i]) key_q[i] = '0;
      nonce_lo  = '0;
      nonce_hi  = '0;
      block_ctr = '0;
      raw_mode  = 1'b0;
      ks_pos    = 64;
      failed    = 1'b0;
    endfunction

    function automatic logic [31:0] rotl(logic [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function automatic void mix(ref logic [31:0] w[16], input int a, int b, int c, int d);
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 16);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 12);
      w[a] = w[a] + w[b]; w[d] = rotl(w[d] ^ w[a], 8);
      w[c] = w[c] + w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    endfunction

    // Runs the block function on the current counter and refills the buffer.
    function void refill();
      logic [31:0] init[16];
      logic [31:0] work[16];
      logic [31:0] sum;
      init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
      for (int i = 0; i < 4; i++) begin
        init[4+2*i] = key_q[i][31:0];
        init[5+2*i] = key_q[i][63:32];
      end
      init[12] = block_ctr;
      init[13] = nonce_lo[31:0];
      init[14] = nonce_lo[63:32];
      init[15] = nonce_hi;
      work = init;
      for (int r = 0; r < DoubleRoundsDef; r++) begin
        mix(work, 0, 4, 8, 12); mix(work, 1, 5, 9, 13);
        mix(work, 2, 6, 10, 14); mix(work, 3, 7, 11, 15);
        mix(work, 0, 5, 10, 15); mix(work, 1, 6, 11, 12);
        mix(work, 2, 7, 8, 13); mix(work, 3, 4, 9, 14);
      end
      for (int k = 0; k < 16; k++) begin
        sum = work[k] + init[k];
        for (int b = 0; b < 4; b++) ks_buf[4*k+b] = sum[8*b +: 8];
      end
      block_ctr = block_ctr + 32'd1;
      ks_pos    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] val);
      case (idx)
        CFG_KEY0:   key_q[0] = val;
        CFG_KEY1:   key_q[1] = val;
        CFG_KEY2:   key_q[2] = val;
        CFG_KEY3:   key_q[3] = val;
        CFG_NONCE0: nonce_lo = val;
        CFG_NONCE1: nonce_hi = val[31:0];
        CFG_CTR: begin
          block_ctr = val[31:0];
          ks_pos    = 64;
        end
        CFG_MODE:   raw_mode = val[0];
        default: ;
      endcase
    endfunction

    // Notes an accepted input transaction.
    function void note_input(logic [7:0] data, logic last);
      logic [7:0] ks;
      if (ks_pos >= 64) refill();
      ks = ks_buf[ks_pos];
      ks_pos++;
      pending_q.push_back({raw_mode ? ks : (data ^ ks), last});
    endfunction

    // Checks an accepted output transaction against the oldest expectation.
    function void check_output(logic [7:0] obyte, logic olast);
      logic [8:0] exp_v;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected output byte %h last %b", $time, obyte, olast);
        failed = 1'b1;
        return;
      end
      exp_v = pending_q.pop_front();
      if (obyte !== exp_v[8:1]) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_v[8:1], obyte);
        failed = 1'b1;
      end
      if (olast !== exp_v[0]) begin
        $display("%0t: last_out expected %b actual %b", $time, exp_v[0], olast);
        failed = 1'b1;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          data_byte_i;
  logic                last_in_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_byte_o;
  logic                last_out_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  cipher_scoreboard sb;
  int unsigned idle_cycles = 0;
  bit          stall_heavy;

  chacha20_stream_cipher_top DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .last_in_i,
    .out_valid_o, .out_stall_i, .out_byte_o, .last_out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Gap length: mostly short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: random stall and checking of accepted transactions.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_output(out_byte_o, last_out_o);
      out_stall_i <= stall_heavy ? ($urandom_range(0, 99) < 40)
                                 : ($urandom_range(0, 99) < 8);
    end
  end

  // Watchdog on cycles with no accepted transaction.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("chacha20_stream_cipher_top: mismatch");
      $finish;
    end
  end

  // Writes one configuration register while the block is idle.
  task automatic write_cfg(input cfg_idx_e idx, input logic [63:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes an out-of-range index, which the block must ignore.
  task automatic write_bad_index(input logic [CfgIdxW-1:0] idx);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= {$urandom, $urandom};
    @(posedge clk_i);
    sb.write_reg(idx, cfg_data_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one byte and waits for its acceptance; valid stays high into the
  // next byte when there is no gap.
  task automatic send_byte(input logic [7:0] data, input logic last, input bit use_gap);
    int unsigned gap;
    gap = use_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_in_i   <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(data, last);
  endtask

  // Ends the input stream, waits until every expected byte has come out,
  // then a short settle time.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (2 * DoubleRoundsDef + 8) @(posedge clk_i);
  endtask

  task automatic random_keys();
    write_cfg(CFG_KEY0, {$urandom, $urandom});
    write_cfg(CFG_KEY1, {$urandom, $urandom});
    write_cfg(CFG_KEY2, {$urandom, $urandom});
    write_cfg(CFG_KEY3, {$urandom, $urandom});
    write_cfg(CFG_NONCE0, {$urandom, $urandom});
    write_cfg(CFG_NONCE1, {$urandom, $urandom});
  endtask

  // Sends a run of random bytes, with a last flag closing each message.
  task automatic random_burst(input int unsigned count, input bit gaps);
    int unsigned msg_left;
    msg_left = $urandom_range(1, 80);
    for (int unsigned i = 0; i < count; i++) begin
      msg_left--;
      send_byte(8'($urandom_range(0, 255)), (msg_left == 0) || (i == count - 1), gaps);
      if (msg_left == 0) msg_left = $urandom_range(1, 80);
    end
  endtask

  initial begin
    logic [7:0] rfc_data[4];
    sb          = new();
    stall_heavy = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_in_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-zero configuration after reset, extreme data values.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0);
    drain();

    // Directed: all-ones key and nonce, counter at the top so it wraps.
    write_cfg(CFG_KEY0, '1);
    write_cfg(CFG_KEY1, '1);
    write_cfg(CFG_KEY2, '1);
    write_cfg(CFG_KEY3, '1);
    write_cfg(CFG_NONCE0, '1);
    write_cfg(CFG_NONCE1, '1);
    write_cfg(CFG_CTR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_bad_index(4'd8);
    write_bad_index(4'd15);
    random_burst(70, 1'b0);
    drain();

    // Directed: keystream-only mode, then back to XOR mode mid-block.
    write_cfg(CFG_MODE, 64'h1);
    for (int i = 0; i < 4; i++) rfc_data[i] = 8'($urandom_range(0, 255));
    for (int i = 0; i < 4; i++) send_byte(rfc_data[i], i[0], 1'b0);
    drain();
    write_cfg(CFG_MODE, 64'h0);
    random_burst(6, 1'b0);
    drain();

    // Directed: new key mid-block affects only the next block.
    random_keys();
    random_burst(60, 1'b1);
    drain();
    write_cfg(CFG_CTR, 64'h0);

    // Random phases with different settings and pressure levels.
    for (int ph = 0; ph < 12; ph++) begin
      stall_heavy = (ph % 3 == 1);
      drain();
      if ($urandom_range(0, 1)) random_keys();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 3))
          0: write_cfg(CFG_CTR, 64'h0);
          1: write_cfg(CFG_CTR, 64'hFFFF_FFFF);
          default: write_cfg(CFG_CTR, {$urandom, $urandom});
        endcase
      end
      write_cfg(CFG_MODE, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : 64'h0);
      random_burst(100, (ph % 4) != 0);
    end
    stall_heavy = 1'b0;
    drain();

    if (!sb.failed) begin
      $display("chacha20_stream_cipher_top: match");
    end else begin
      $display("chacha20_stream_cipher_top: mismatch");
    end
    $finish;
  end

endmodule
